/* design/wsad_pkg.sv */
// ----------------------------------------------------------------------------
// wsad_pkg
// shared constants and the alert word type of the window sigma detector
// ----------------------------------------------------------------------------
package wsad_pkg;

  localparam int WINDOW_DEF       = 10;
  localparam int NEWTON_STEPS_DEF = 10;
  localparam int SAMPLE_BITS_DEF  = 7;

  localparam int SIGMA_W     = 3;
  localparam int INDEX_W     = 16;
  localparam int REPORT_W    = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIGMA_W-1:0] SIGMA_RESET = 3'd3;

  typedef struct packed {
    logic [INDEX_W-1:0]  sample_index;
    logic                follow_up;
    logic [REPORT_W-1:0] window_mean;
    logic [REPORT_W-1:0] window_deviation;
  } alert_t;

endpackage

/* design/window_sigma_anomaly_detector_unit.sv */
// the back end works on one sample at a time: window sweeps, then at most
//   NEWTON_STEPS newton steps, and output stalls can hold it; a two-entry
//   queue keeps the input taking words
// reset: synchronous, clears window fill, latch, index and sets k to 3
// ----------------------------------------------------------------------------
// window_sigma_anomaly_detector_unit
// sliding window mean/deviation outlier detector with follow-up alerts
// ----------------------------------------------------------------------------
module window_sigma_anomaly_detector_unit import wsad_pkg::*; #(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration word: sigma multiplier k
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SIGMA_W-1:0]     sigma_multiplier,
  // sample input words
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic [SAMPLE_BITS-1:0] sample,
  // alert output words
  output logic                   alert_valid,
  input  logic                   alert_stall,
  output logic [INDEX_W-1:0]     sample_index,
  output logic                   follow_up,
  output logic [REPORT_W-1:0]    window_mean,
  output logic [REPORT_W-1:0]    window_deviation
);

  localparam int QW = INDEX_W + SAMPLE_BITS;

  // queue between front and back, each word is {index, sample}
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_in;
  logic [QW-1:0] q_out;
  logic [SIGMA_W-1:0] sigma;
  alert_t        result;

  // front: takes samples while the queue has room, numbers them
  wsad_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (sigma_multiplier),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in),
    .sigma        (sigma)
  );

  wsad_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  // back: window sweeps, reciprocal divides by WINDOW, newton root, band test
  wsad_back #(
    .WINDOW       (WINDOW),
    .NEWTON_STEPS (NEWTON_STEPS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .sigma       (sigma),
    .alert_valid (alert_valid),
    .alert_stall (alert_stall),
    .result      (result)
  );

  // output register fields straight to the ports
  assign sample_index     = result.sample_index;
  assign follow_up        = result.follow_up;
  assign window_mean      = result.window_mean;
  assign window_deviation = result.window_deviation;

endmodule

/* design/wsad_front.sv */
// ----------------------------------------------------------------------------
// wsad_front
// accepts samples, tags them with their running index, holds the k register
// ----------------------------------------------------------------------------
module wsad_front import wsad_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [SIGMA_W-1:0]             cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [SAMPLE_BITS-1:0]         sample,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [INDEX_W+SAMPLE_BITS-1:0] q_data,
  output logic [SIGMA_W-1:0]             sigma
);

  logic [INDEX_W-1:0] index;

  assign cfg_ready    = 1'b1;
  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;
  assign q_data       = {index, sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
      sigma <= SIGMA_RESET;
    end else begin
      if (q_push) begin
        index <= index + 1'b1;
      end
      if (cfg_valid) begin
        sigma <= cfg_data;
      end
    end
  end

endmodule

/* design/wsad_fifo.sv */
// ----------------------------------------------------------------------------
// wsad_fifo
// short queue between the front and the back
// ----------------------------------------------------------------------------
module wsad_fifo import wsad_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/wsad_div.sv */
// ----------------------------------------------------------------------------
// wsad_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsad_div #(
  parameter int W = 18
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    rem_sh;
  logic [W:0]    diff;
  logic          ge;

  assign rem_sh   = {rem[W-1:0], quo[W-1]};
  assign diff     = rem_sh - {1'b0, dsr};
  assign ge       = !diff[W];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // pulse on the edge that shifts in the last quotient bit
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? diff : rem_sh;
      quo <= {quo[W-2:0], ge};
    end
  end

endmodule

/* design/wsad_back.sv */
// ----------------------------------------------------------------------------
// wsad_back
// window statistics, newton root, band test and the alert output register
// ----------------------------------------------------------------------------
module wsad_back import wsad_pkg::*; #(
  parameter int WINDOW       = WINDOW_DEF,
  parameter int NEWTON_STEPS = NEWTON_STEPS_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  logic [INDEX_W+SAMPLE_BITS-1:0] q_data,
  input  logic [SIGMA_W-1:0]             sigma,
  output logic                           alert_valid,
  input  logic                           alert_stall,
  output alert_t                         result
);

  localparam int SB    = SAMPLE_BITS;
  localparam int AW    = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int CW    = $clog2(WINDOW + 2);
  localparam int SUM_W = SB + $clog2(WINDOW);
  localparam int DW    = 2 * SB + $clog2(WINDOW);
  localparam int SP_W  = DW + SIGMA_W;
  localparam int NW    = $clog2(NEWTON_STEPS + 1);

  // divide by WINDOW as a multiply by a rounded-up reciprocal, exact below 2^DW
  localparam int RS   = DW + $clog2(WINDOW);
  localparam int RP_W = RS + DW;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RS) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [DW:0] RECIP = (DW + 1)'(RECIP_L);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_MEAN_DIV, ST_SQ, ST_VAR_DIV,
    ST_NEWT, ST_NEWT_DIV, ST_SPAN, ST_TEST
  } state_t;

  state_t              state;
  logic [SB-1:0]       x;
  logic [INDEX_W-1:0]  idx;
  logic [CW-1:0]       cnt;
  logic [SUM_W-1:0]    sum;
  logic [SB-1:0]       mean;
  logic [2*SB-1:0]     prod;
  logic                prod_v;
  logic [DW-1:0]       sq;
  logic [DW-1:0]       n;
  logic [DW-1:0]       s;
  logic [DW-1:0]       t;
  logic [NW-1:0]       steps;
  logic [SP_W-1:0]     span;
  logic                latch;
  logic [AW-1:0]       wp;
  logic [FW-1:0]       fill;
  logic                div_start;
  logic                div_done;
  logic [DW-1:0]       div_q;
  logic                newt_stop;
  logic [DW-1:0]       recip_in;
  logic [RP_W-1:0]     recip_prod;
  logic [DW-1:0]       recip_q;

  // window memory, entries past the fill count read as zero
  logic [SB-1:0]       mem [WINDOW];
  logic [AW-1:0]       rd_addr;
  logic [SB-1:0]       rd_data;
  logic                rd_ok;
  logic                mem_we;

  logic [SB-1:0]       v;
  logic [SB-1:0]       d;
  logic [SUM_W-1:0]    sum_next;
  logic [DW-1:0]       sq_next;
  logic [DW:0]         root_sum;
  logic                out_free;
  logic                full;
  logic                above;
  logic                below;

  assign rd_addr    = cnt[AW-1:0];
  assign v          = rd_ok ? rd_data : '0;
  assign d          = (v > mean) ? (v - mean) : (mean - v);
  assign sum_next   = sum + SUM_W'(v);
  assign sq_next    = sq + (prod_v ? DW'(prod) : '0);
  assign root_sum   = {1'b0, div_q} + {1'b0, t};
  assign out_free   = !alert_valid || !alert_stall;
  assign full       = (fill == FW'(WINDOW));
  assign above      = ((SP_W + 1)'(x) > (SP_W + 1)'(mean) + (SP_W + 1)'(span));
  assign below      = ((SP_W + 1)'(x) + (SP_W + 1)'(span) < (SP_W + 1)'(mean));
  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign mem_we     = (state == ST_TEST) && out_free;
  assign recip_prod = RP_W'(recip_in) * RP_W'(RECIP);
  assign recip_q    = recip_prod[RP_W-1:RS];
  assign newt_stop  = (s == t) || (steps == NW'(NEWTON_STEPS)) || (s == '0);
  assign div_start  = (state == ST_NEWT) && !newt_stop;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= x;
    end
    rd_data <= mem[rd_addr];
    rd_ok   <= (FW'(rd_addr) < fill);
  end

  // newton step n / s, operands taken on the start edge
  wsad_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (n),
    .divisor  (s),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      alert_valid <= 1'b0;
      latch       <= 1'b0;
      wp          <= '0;
      fill        <= '0;
      prod_v      <= 1'b0;
    end else begin
      if (alert_valid && !alert_stall && state != ST_TEST) begin
        alert_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            x     <= q_data[SB-1:0];
            idx   <= q_data[INDEX_W+SB-1:SB];
            cnt   <= '0;
            sum   <= '0;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (cnt == CW'(WINDOW)) begin
            recip_in <= DW'(sum_next);
            state    <= ST_MEAN_DIV;
          end else begin
            if (cnt != '0) begin
              sum <= sum_next;
            end
            cnt <= cnt + 1'b1;
          end
        end
        ST_MEAN_DIV: begin
          mean   <= recip_q[SB-1:0];
          cnt    <= '0;
          sq     <= '0;
          prod_v <= 1'b0;
          state  <= ST_SQ;
        end
        ST_SQ: begin
          // read, then square, then accumulate
          if (cnt != '0 && cnt <= CW'(WINDOW)) begin
            prod   <= d * d;
            prod_v <= 1'b1;
          end else begin
            prod_v <= 1'b0;
          end
          sq <= sq_next;
          if (cnt == CW'(WINDOW + 1)) begin
            recip_in <= sq_next;
            state    <= ST_VAR_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_VAR_DIV: begin
          n     <= recip_q;
          s     <= recip_q >> 1;
          t     <= '0;
          steps <= '0;
          state <= ST_NEWT;
        end
        ST_NEWT: begin
          if (newt_stop) begin
            state <= ST_SPAN;
          end else begin
            t     <= s;
            steps <= steps + 1'b1;
            state <= ST_NEWT_DIV;
          end
        end
        ST_NEWT_DIV: begin
          if (div_done) begin
            s     <= root_sum[DW:1];
            state <= ST_NEWT;
          end
        end
        ST_SPAN: begin
          span  <= SP_W'(sigma) * SP_W'(s);
          state <= ST_TEST;
        end
        ST_TEST: begin
          if (out_free) begin
            result.sample_index     <= idx;
            result.window_mean      <= mean[REPORT_W-1:0];
            result.window_deviation <= s[REPORT_W-1:0];
            if (full && (above || below)) begin
              latch            <= 1'b1;
              alert_valid      <= 1'b1;
              result.follow_up <= 1'b0;
            end else if (full && latch) begin
              latch            <= 1'b0;
              alert_valid      <= 1'b1;
              result.follow_up <= 1'b1;
            end else begin
              alert_valid <= 1'b0;
            end
            wp <= (wp == AW'(WINDOW - 1)) ? '0 : wp + 1'b1;
            if (!full) begin
              fill <= fill + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* bench/window_sigma_anomaly_detector_unit_tb.sv */
// ----------------------------------------------------------------------------
// window_sigma_anomaly_detector_unit_tb
// drives oxygen-saturation sample words into the detector and checks the
// alert words against a cycle-free model of the sliding window, its mean,
// its newton deviation and the follow-up latch, over several sigma settings
// ----------------------------------------------------------------------------
module window_sigma_anomaly_detector_unit_tb;
  import wsad_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run bounds: drain covers a full input queue plus one word in flight
  localparam int DRAIN_CYCLES  = 1000;
  localparam int SETTLE_CYCLES = 5000;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS_DEF) - 1;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [SIGMA_W-1:0]         sigma_multiplier = '0;
  logic                       sample_valid = 1'b0;
  logic                       sample_stall;
  logic [SAMPLE_BITS_DEF-1:0] sample = '0;
  logic                       alert_valid;
  logic                       alert_stall = 1'b0;
  logic [INDEX_W-1:0]         sample_index;
  logic                       follow_up;
  logic [REPORT_W-1:0]        window_mean;
  logic [REPORT_W-1:0]        window_deviation;

  window_sigma_anomaly_detector_unit uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .sigma_multiplier (sigma_multiplier),
    .sample_valid     (sample_valid),
    .sample_stall     (sample_stall),
    .sample           (sample),
    .alert_valid      (alert_valid),
    .alert_stall      (alert_stall),
    .sample_index     (sample_index),
    .follow_up        (follow_up),
    .window_mean      (window_mean),
    .window_deviation (window_deviation)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state of the detector
  logic [SAMPLE_BITS_DEF-1:0] win_copy [WINDOW_DEF];
  int unsigned                wr_slot  = 0;
  int unsigned                filled   = 0;
  bit                         latched  = 1'b0;
  logic [INDEX_W-1:0]         next_idx = '0;
  logic [SIGMA_W-1:0]         k_now    = SIGMA_RESET;

  // words waiting for the driver, and alerts waiting for the monitor
  logic [SAMPLE_BITS_DEF-1:0] pending_words [$];
  alert_t                     alerts_due [$];

  int  words_queued = 0;
  int  words_taken  = 0;
  int  errors       = 0;
  int  cycles       = 0;
  bit  calm         = 1'b0;   // no idling on either side while set
  int  gap_left     = 0;
  int  hold_left    = 0;

  initial begin
    for (int i = 0; i < WINDOW_DEF; i++) win_copy[i] = '0;
  end

  // integer square root, newton steps from n/2, capped step count
  function automatic longint unsigned newton_isqrt(input longint unsigned n);
    longint unsigned prev;
    longint unsigned s;
    int              steps;
    prev  = 0;
    s     = n / 2;
    steps = 0;
    while (s != prev && steps < NEWTON_STEPS_DEF && s != 0) begin
      prev = s;
      s = (n / prev + prev) / 2;
      steps++;
    end
    return s;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // test one accepted word against the window, then insert it
  task automatic update_window_alert(input logic [SAMPLE_BITS_DEF-1:0] word);
    longint unsigned total;
    longint unsigned sq_sum;
    longint unsigned avg;
    longint unsigned spread;
    longint unsigned delta;
    longint signed   band;
    longint signed   upper;
    longint signed   lower;
    longint signed   xs;
    alert_t          a;
    bit              hit;
    int              i;
    total  = 0;
    sq_sum = 0;
    hit    = 1'b0;
    a      = '0;
    // mean and variance include never-written zero entries
    for (i = 0; i < WINDOW_DEF; i++) total += win_copy[i];
    avg = total / WINDOW_DEF;
    for (i = 0; i < WINDOW_DEF; i++) begin
      delta = (win_copy[i] > avg) ? win_copy[i] - avg : avg - win_copy[i];
      sq_sum += delta * delta;
    end
    spread = newton_isqrt(sq_sum / WINDOW_DEF);
    // no test until the window holds real samples only
    if (filled >= WINDOW_DEF) begin
      band  = longint'(k_now) * longint'(spread);
      upper = longint'(avg) + band;
      lower = longint'(avg) - band;   // may go below zero
      xs    = longint'(word);
      if (xs > upper || xs < lower) begin
        hit     = 1'b1;
        latched = 1'b1;
      end else if (latched) begin
        hit         = 1'b1;
        a.follow_up = 1'b1;
        latched     = 1'b0;
      end
      if (hit) begin
        a.sample_index     = next_idx;
        a.window_mean      = REPORT_W'(avg);
        a.window_deviation = REPORT_W'(spread);
        alerts_due.push_back(a);
      end
    end
    win_copy[wr_slot] = word;
    wr_slot = (wr_slot + 1) % WINDOW_DEF;
    if (filled < WINDOW_DEF) filled++;
    next_idx++;
  endtask

  // sample driver: one word held until taken, then a random gap
  always @(posedge clk) begin
    bit busy;
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = sample_valid;
      if (sample_valid && !sample_stall) begin
        update_window_alert(sample);
        words_taken++;   // after the push so the idle check sees both
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          sample       <= pending_words.pop_front();
          sample_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // alert monitor: compare every taken word with the oldest expectation
  always @(posedge clk) begin
    alert_t want;
    if (rst) begin
      alert_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (alert_valid && !alert_stall) begin
        if (alerts_due.size() == 0) begin
          $error("alert word with none expected: index %0d", sample_index);
          errors++;
        end else begin
          want = alerts_due.pop_front();
          if (sample_index !== want.sample_index) begin
            $error("sample_index: expected %0d, got %0d", want.sample_index, sample_index);
            errors++;
          end
          if (follow_up !== want.follow_up) begin
            $error("follow_up: expected %0d, got %0d", want.follow_up, follow_up);
            errors++;
          end
          if (window_mean !== want.window_mean) begin
            $error("window_mean: expected %0d, got %0d", want.window_mean, window_mean);
            errors++;
          end
          if (window_deviation !== want.window_deviation) begin
            $error("window_deviation: expected %0d, got %0d",
                   want.window_deviation, window_deviation);
            errors++;
          end
        end
      end
      // stall pattern is independent of alert_valid
      if (hold_left > 0) begin
        hold_left--;
        alert_stall <= 1'b1;
      end else begin
        alert_stall <= 1'b0;
        hold_left = pick_gap();
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_word(input int v);
    pending_words.push_back(SAMPLE_BITS_DEF'(v));
    words_queued++;
  endtask

  // all words taken, all alerts seen, then let the back end run dry
  task automatic wait_idle();
    int n;
    while (words_taken != words_queued) @(posedge clk);
    n = 0;
    while (alerts_due.size() != 0 && n < SETTLE_CYCLES) begin
      @(posedge clk);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (alerts_due.size() != 0) begin
      $error("%0d alert words never arrived", alerts_due.size());
      errors++;
      alerts_due.delete();
    end
  endtask

  // sigma write, only issued while the detector is idle
  task automatic write_sigma(input logic [SIGMA_W-1:0] k);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    sigma_multiplier <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    k_now = k;
  endtask

  // steady readings around a level with small noise, spikes and extremes
  task automatic queue_readings(input int count);
    int left;
    int seg;
    int level;
    int wiggle;
    int r;
    int v;
    left = count;
    while (left > 0) begin
      seg    = $urandom_range(10, 40);
      level  = $urandom_range(0, SAMPLE_MAX);
      wiggle = $urandom_range(0, 6);
      // now and then a segment of plain noise
      if ($urandom_range(0, 7) == 0) wiggle = SAMPLE_MAX;
      while (seg > 0 && left > 0) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          v = level + $urandom_range(0, 2 * wiggle) - wiggle;
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        end else if (r < 92) begin
          v = $urandom_range(0, SAMPLE_MAX);
        end else begin
          v = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
        end
        queue_word(v);
        seg--;
        left--;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset value of k: extremes while filling, then a flat window
    // (zero deviation), an outlier below and a follow-up after it
    queue_word(0);
    queue_word(SAMPLE_MAX);
    repeat (10) queue_word(100);
    queue_word(0);
    queue_word(100);
    queue_word(SAMPLE_MAX);
    queue_word(SAMPLE_MAX);
    queue_word(64);
    queue_word(0);
    queue_word(SAMPLE_MAX);
    wait_idle();

    // k = 0: every sample off the mean alerts
    write_sigma('0);
    queue_readings(60);
    wait_idle();

    // k = 7, no idling on either side
    calm = 1'b1;
    write_sigma('1);
    queue_readings(60);
    wait_idle();
    calm = 1'b0;

    // random settings
    repeat (7) begin
      calm = ($urandom_range(0, 3) == 0);
      write_sigma(SIGMA_W'($urandom_range(0, 7)));
      queue_readings(70);
      wait_idle();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/wsad_pkg.sv
design/wsad_front.sv
design/wsad_fifo.sv
design/wsad_div.sv
design/wsad_back.sv
design/window_sigma_anomaly_detector_unit.sv
bench/window_sigma_anomaly_detector_unit_tb.sv
